// File: rtl/parl_pkg.sv
`timescale 1ns / 1ps

package parl_pkg;

  localparam int LOG_DEPTH_DEF = 32;

  localparam int SEG_W = 16;
  localparam int SRC_W = 16;
  localparam int ADDR_W = 64;
  localparam int LEN_W = 64;
  localparam int ACC_W = 2;

  // Action codes of an input word
  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_DRAIN  = 1'b1;

  // Status codes of a result word
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef struct packed {
    logic [SEG_W-1:0]  segment;
    logic [SRC_W-1:0]  source_id;
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  length;
    logic [ACC_W-1:0]  access;
  } parl_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_APPEND,
    ST_DRAIN_RD,
    ST_DRAIN_OUT
  } parl_state_t;

endpackage

// File: rtl/pending_access_request_log.sv
`timescale 1ns / 1ps
// Record: a grant passes ST_APPEND, then answers from resp_r; a revoke scans each entry in
//   ST_SCAN_RD/ST_SCAN_CMP, and on a hit moves each later entry in ST_SHIFT_RD/ST_SHIFT_WR.
// Drain: one result per stored entry from ST_DRAIN_OUT; an empty drain answers via resp_r.
// Throughput: one word at a time; busy stays high until the final (out_last) result.
// Cycle count is set by the single read port of the log memory and the shared comparator.
// Reset (rst_n low, synchronous): log emptied, sequencer idle; the receiver cannot stall.
module pending_access_request_log #(
  parameter int LOG_DEPTH = parl_pkg::LOG_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_action,
  input  logic [parl_pkg::SEG_W-1:0]  in_segment,
  input  logic [parl_pkg::SRC_W-1:0]  in_source_id,
  input  logic [parl_pkg::ADDR_W-1:0] in_base_address,
  input  logic [parl_pkg::LEN_W-1:0]  in_length,
  input  logic [parl_pkg::ACC_W-1:0]  in_access,
  output logic                        out_valid,
  output logic                        out_status,
  output logic                        out_entry_valid,
  output logic [parl_pkg::SEG_W-1:0]  out_segment,
  output logic [parl_pkg::SRC_W-1:0]  out_source_id,
  output logic [parl_pkg::ADDR_W-1:0] out_base,
  output logic [parl_pkg::LEN_W-1:0]  out_length,
  output logic [parl_pkg::ACC_W-1:0]  out_access,
  output logic                        out_last
);

  localparam int AW = $clog2(LOG_DEPTH);
  localparam int CW = $clog2(LOG_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(LOG_DEPTH);

  parl_pkg::parl_state_t state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic                  resp_full_r, resp_full_nxt;
  logic                  resp_r, resp_nxt;
  parl_pkg::parl_entry_t key_r;

  logic                  mem_wr_en;
  logic [AW-1:0]         mem_wr_addr;
  parl_pkg::parl_entry_t mem_wr_data;
  logic [AW-1:0]         mem_rd_addr;
  parl_pkg::parl_entry_t mem_rd_data;
  logic                  hit;
  logic                  idx_is_last;
  logic                  accept;

  parl_log_mem #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_mem (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_data   (mem_wr_data),
    .rd_addr   (mem_rd_addr),
    .rd_data_r (mem_rd_data)
  );

  // Shared comparator: key against the entry just read
  parl_cmp u_cmp (
    .key   (key_r),
    .cand  (mem_rd_data),
    .match (hit)
  );

  assign accept      = start && !busy;
  assign idx_is_last = ((CW'(idx_r) + CW'(1)) == cnt_r);

  // Hold the request key for the scan and the append
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r.segment   <= in_segment;
      key_r.source_id <= in_source_id;
      key_r.base      <= in_base_address;
      key_r.length    <= in_length;
      key_r.access    <= in_access;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= parl_pkg::ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      resp_full_r <= 1'b0;
      resp_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      resp_full_r <= resp_full_nxt;
      resp_r      <= resp_nxt;
    end
  end

  // Sequencer. resp_r marks the single-cycle answer of a record word or an empty drain;
  // it is raised together with the return to idle-side state, so busy covers it.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    resp_full_nxt = 1'b0;
    resp_nxt      = 1'b0;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = idx_r;
    mem_wr_data   = mem_rd_data;
    mem_rd_addr   = idx_r;
    out_valid     = 1'b0;
    out_status    = parl_pkg::ST_OK;
    out_entry_valid = 1'b0;
    out_last      = 1'b0;

    // Present a pending record or empty-drain answer
    if (resp_r) begin
      out_valid  = 1'b1;
      out_status = resp_full_r;
      out_last   = 1'b1;
    end

    unique case (state_r)
      parl_pkg::ST_IDLE: begin
        if (accept && !resp_r) begin
          idx_nxt = '0;
          if (in_action == parl_pkg::ACT_DRAIN) begin
            if (cnt_r == '0) begin
              resp_nxt = 1'b1;
            end else begin
              state_nxt = parl_pkg::ST_DRAIN_RD;
            end
          end else if ((in_access == '0) && (cnt_r != '0)) begin
            state_nxt = parl_pkg::ST_SCAN_RD;
          end else begin
            state_nxt = parl_pkg::ST_APPEND;
          end
        end
      end
      parl_pkg::ST_SCAN_RD: begin
        state_nxt = parl_pkg::ST_SCAN_CMP;
      end
      parl_pkg::ST_SCAN_CMP: begin
        priority if (hit) begin
          state_nxt = parl_pkg::ST_SHIFT_RD;
        end else if (idx_is_last) begin
          state_nxt = parl_pkg::ST_APPEND;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = parl_pkg::ST_SCAN_RD;
        end
      end
      parl_pkg::ST_SHIFT_RD: begin
        // Close the hole: fetch the next entry, or drop the tail slot
        mem_rd_addr = idx_r + AW'(1);
        if (idx_is_last) begin
          cnt_nxt   = cnt_r - CW'(1);
          resp_nxt  = 1'b1;
          state_nxt = parl_pkg::ST_IDLE;
        end else begin
          state_nxt = parl_pkg::ST_SHIFT_WR;
        end
      end
      parl_pkg::ST_SHIFT_WR: begin
        mem_wr_en = 1'b1;
        idx_nxt   = idx_r + AW'(1);
        state_nxt = parl_pkg::ST_SHIFT_RD;
      end
      parl_pkg::ST_APPEND: begin
        if (cnt_r == DEPTH_C) begin
          resp_full_nxt = parl_pkg::ST_FULL;
        end else begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = cnt_r[AW-1:0];
          mem_wr_data = key_r;
          cnt_nxt     = cnt_r + CW'(1);
        end
        resp_nxt  = 1'b1;
        state_nxt = parl_pkg::ST_IDLE;
      end
      parl_pkg::ST_DRAIN_RD: begin
        state_nxt = parl_pkg::ST_DRAIN_OUT;
      end
      parl_pkg::ST_DRAIN_OUT: begin
        out_valid       = 1'b1;
        out_entry_valid = 1'b1;
        out_last        = idx_is_last;
        if (idx_is_last) begin
          cnt_nxt   = '0;
          state_nxt = parl_pkg::ST_IDLE;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = parl_pkg::ST_DRAIN_RD;
        end
      end
      default: begin
        state_nxt = parl_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != parl_pkg::ST_IDLE) || resp_r;

  // Entry fields read as zero unless a drained entry is carried
  assign out_segment   = out_entry_valid ? mem_rd_data.segment   : '0;
  assign out_source_id = out_entry_valid ? mem_rd_data.source_id : '0;
  assign out_base      = out_entry_valid ? mem_rd_data.base      : '0;
  assign out_length    = out_entry_valid ? mem_rd_data.length    : '0;
  assign out_access    = out_entry_valid ? mem_rd_data.access    : '0;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("entry count above log depth");

  a_out_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result word while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted word did not raise busy");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !busy)
    else $error("still busy after final result");

  a_plain_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_entry_valid) |-> out_last)
    else $error("record answer without last mark");

endmodule

// File: rtl/parl_log_mem.sv
`timescale 1ns / 1ps

module parl_log_mem #(
  parameter int LOG_DEPTH = parl_pkg::LOG_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(LOG_DEPTH)-1:0] wr_addr,
  input  parl_pkg::parl_entry_t        wr_data,
  input  logic [$clog2(LOG_DEPTH)-1:0] rd_addr,
  output parl_pkg::parl_entry_t        rd_data_r
);

  parl_pkg::parl_entry_t mem [LOG_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

// File: rtl/parl_cmp.sv
`timescale 1ns / 1ps

module parl_cmp (
  input  parl_pkg::parl_entry_t key,
  input  parl_pkg::parl_entry_t cand,
  output logic                  match
);

  // Match on range identity; only a granting entry can be revoked
  assign match = (key.segment == cand.segment) &&
                 (key.source_id == cand.source_id) &&
                 (key.base == cand.base) &&
                 (key.length == cand.length) &&
                 (cand.access != '0);

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH     = parl_pkg::LOG_DEPTH_DEF;
  localparam int POOL_SIZE = 6;
  localparam int RAND_WORDS = 400;

  // One expected result word, laid out like the result ports.
  typedef struct {
    logic                  status;
    logic                  entry_valid;
    parl_pkg::parl_entry_t data;
    logic                  last;
  } log_result_t;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic                        in_action;
  logic [parl_pkg::SEG_W-1:0]  in_segment;
  logic [parl_pkg::SRC_W-1:0]  in_source_id;
  logic [parl_pkg::ADDR_W-1:0] in_base_address;
  logic [parl_pkg::LEN_W-1:0]  in_length;
  logic [parl_pkg::ACC_W-1:0]  in_access;
  logic                        out_valid;
  logic                        out_status;
  logic                        out_entry_valid;
  logic [parl_pkg::SEG_W-1:0]  out_segment;
  logic [parl_pkg::SRC_W-1:0]  out_source_id;
  logic [parl_pkg::ADDR_W-1:0] out_base;
  logic [parl_pkg::LEN_W-1:0]  out_length;
  logic [parl_pkg::ACC_W-1:0]  out_access;
  logic                        out_last;

  // Shadow copy of the request log and the words it still owes.
  parl_pkg::parl_entry_t shadow_log [DEPTH];
  int                    shadow_count;
  log_result_t           expected_words [$];
  log_result_t           head_word;

  // Keys that recur, so revokes find their grants.
  parl_pkg::parl_entry_t key_pool [POOL_SIZE];

  int words_sent;
  int fail_count;

  pending_access_request_log #(
    .LOG_DEPTH(DEPTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_segment      (in_segment),
    .in_source_id    (in_source_id),
    .in_base_address (in_base_address),
    .in_length       (in_length),
    .in_access       (in_access),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_valid (out_entry_valid),
    .out_segment     (out_segment),
    .out_source_id   (out_source_id),
    .out_base        (out_base),
    .out_length      (out_length),
    .out_access      (out_access),
    .out_last        (out_last)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Bias wide values toward all zeros and all ones now and then.
  function automatic logic [63:0] rand_wide();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic parl_pkg::parl_entry_t fresh_key();
    parl_pkg::parl_entry_t k;
    k.segment   = 16'(rand_wide());
    k.source_id = 16'(rand_wide());
    k.base      = rand_wide();
    k.length    = rand_wide();
    k.access    = 2'($urandom_range(0, 3));
    return k;
  endfunction

  // Pick a recurring key; sometimes nudge one field to make a near miss.
  function automatic parl_pkg::parl_entry_t pool_key();
    parl_pkg::parl_entry_t k;
    k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    case ($urandom_range(0, 9))
      0: k.base      = k.base + 64'd1;
      1: k.length    = k.length ^ 64'h8000_0000_0000_0000;
      2: k.source_id = k.source_id ^ 16'h0001;
      3: k.segment   = k.segment ^ 16'h8000;
      default: ;
    endcase
    return k;
  endfunction

  // Copy the key of an entry that is in the log right now.
  function automatic parl_pkg::parl_entry_t stored_key();
    return shadow_log[$urandom_range(0, shadow_count - 1)];
  endfunction

  function automatic parl_pkg::parl_entry_t make_key(
    input logic [parl_pkg::SEG_W-1:0]  seg,
    input logic [parl_pkg::SRC_W-1:0]  src,
    input logic [parl_pkg::ADDR_W-1:0] base,
    input logic [parl_pkg::LEN_W-1:0]  len,
    input logic [parl_pkg::ACC_W-1:0]  acc);
    parl_pkg::parl_entry_t k;
    k.segment   = seg;
    k.source_id = src;
    k.base      = base;
    k.length    = len;
    k.access    = acc;
    return k;
  endfunction

  // Gap before a word: mostly none or short, a few long.
  function automatic int pick_gap(input bit no_idle);
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Apply one accepted word to the shadow log and queue the words it causes.
  task automatic predict_word(input logic action, input parl_pkg::parl_entry_t req);
    log_result_t res;
    int          hit;
    res.status      = parl_pkg::ST_OK;
    res.entry_valid = 1'b0;
    res.data        = '0;
    res.last        = 1'b1;
    if (action == parl_pkg::ACT_DRAIN) begin
      if (shadow_count == 0) begin
        expected_words.push_back(res);
      end else begin
        for (int i = 0; i < shadow_count; i++) begin
          res.entry_valid = 1'b1;
          res.data        = shadow_log[i];
          res.last        = (i == shadow_count - 1);
          expected_words.push_back(res);
        end
        shadow_count = 0;
      end
    end else begin
      hit = -1;
      // A revoke cancels the earliest live grant with the same key.
      if (req.access == '0) begin
        for (int i = 0; i < shadow_count; i++) begin
          if (hit < 0 && shadow_log[i].segment == req.segment &&
              shadow_log[i].source_id == req.source_id &&
              shadow_log[i].base == req.base && shadow_log[i].length == req.length &&
              shadow_log[i].access != '0)
            hit = i;
        end
      end
      if (hit >= 0) begin
        for (int j = hit; j + 1 < shadow_count; j++)
          shadow_log[j] = shadow_log[j + 1];
        shadow_count--;
      end else if (shadow_count >= DEPTH) begin
        res.status = parl_pkg::ST_FULL;
      end else begin
        shadow_log[shadow_count] = req;
        shadow_count++;
      end
      expected_words.push_back(res);
    end
  endtask

  // Present one word, hold it until the block takes it, then predict.
  task automatic send_word(input logic action, input parl_pkg::parl_entry_t req,
                           input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_action       <= action;
    in_segment      <= req.segment;
    in_source_id    <= req.source_id;
    in_base_address <= req.base;
    in_length       <= req.length;
    in_access       <= req.access;
    do @(posedge clk); while (busy !== 1'b0);
    predict_word(action, req);
    words_sent++;
  endtask

  // Compare every strobed result word against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (expected_words.size() == 0) begin
        $error("result word with no expectation pending");
        fail_count++;
      end else begin
        head_word = expected_words.pop_front();
        if (out_status !== head_word.status) begin
          $error("out_status: expected %h, got %h", head_word.status, out_status);
          fail_count++;
        end
        if (out_entry_valid !== head_word.entry_valid) begin
          $error("out_entry_valid: expected %h, got %h", head_word.entry_valid,
                 out_entry_valid);
          fail_count++;
        end
        if (out_segment !== head_word.data.segment) begin
          $error("out_segment: expected %h, got %h", head_word.data.segment, out_segment);
          fail_count++;
        end
        if (out_source_id !== head_word.data.source_id) begin
          $error("out_source_id: expected %h, got %h", head_word.data.source_id,
                 out_source_id);
          fail_count++;
        end
        if (out_base !== head_word.data.base) begin
          $error("out_base: expected %h, got %h", head_word.data.base, out_base);
          fail_count++;
        end
        if (out_length !== head_word.data.length) begin
          $error("out_length: expected %h, got %h", head_word.data.length, out_length);
          fail_count++;
        end
        if (out_access !== head_word.data.access) begin
          $error("out_access: expected %h, got %h", head_word.data.access, out_access);
          fail_count++;
        end
        if (out_last !== head_word.last) begin
          $error("out_last: expected %h, got %h", head_word.last, out_last);
          fail_count++;
        end
      end
    end
  end

  // Drain straight after reset: one empty, invalid word.
  task automatic test_empty_drain();
    send_word(parl_pkg::ACT_DRAIN, fresh_key(), 0);
  endtask

  // Extreme field values, duplicate keys and revokes that miss.
  task automatic test_field_extremes();
    parl_pkg::parl_entry_t k_zero;
    parl_pkg::parl_entry_t k_ones;
    parl_pkg::parl_entry_t k_alt;
    parl_pkg::parl_entry_t k_miss;
    k_zero = make_key('0, '0, '0, '0, 2'd1);
    k_ones = make_key('1, '1, '1, '1, 2'd3);
    k_alt  = make_key(16'hAAAA, 16'h5555, 64'hAAAA_AAAA_AAAA_AAAA,
                      64'h5555_5555_5555_5555, 2'd2);
    k_miss = make_key(16'h5555, 16'hAAAA, 64'h5555_5555_5555_5555,
                      64'hAAAA_AAAA_AAAA_AAAA, 2'd0);
    send_word(parl_pkg::ACT_RECORD, k_zero, pick_gap(1'b0));
    send_word(parl_pkg::ACT_RECORD, k_ones, pick_gap(1'b0));
    send_word(parl_pkg::ACT_RECORD, k_alt, pick_gap(1'b0));
    // Revoke with no grant behind it: appended as is, twice.
    send_word(parl_pkg::ACT_RECORD, k_miss, pick_gap(1'b0));
    send_word(parl_pkg::ACT_RECORD, k_miss, pick_gap(1'b0));
    k_zero.access = 2'd2;
    send_word(parl_pkg::ACT_RECORD, k_zero, pick_gap(1'b0));
    // Revoke of the all-zero key drops the first copy only.
    k_zero.access = 2'd0;
    send_word(parl_pkg::ACT_RECORD, k_zero, pick_gap(1'b0));
    send_word(parl_pkg::ACT_DRAIN, k_ones, pick_gap(1'b0));
    send_word(parl_pkg::ACT_DRAIN, k_alt, 0);
  endtask

  // Revokes keep the order of the entries that stay behind.
  task automatic test_revoke_order();
    parl_pkg::parl_entry_t k_x;
    parl_pkg::parl_entry_t k_y;
    parl_pkg::parl_entry_t k_near;
    k_x = make_key(16'h0001, 16'h00F8, 64'h0000_0000_8000_0000, 64'h1000, 2'd1);
    k_y = make_key(16'h0001, 16'h00F8, 64'h0000_0000_8000_0000, 64'h2000, 2'd2);
    send_word(parl_pkg::ACT_RECORD, k_x, pick_gap(1'b0));
    send_word(parl_pkg::ACT_RECORD, k_y, pick_gap(1'b0));
    k_x.access = 2'd3;
    send_word(parl_pkg::ACT_RECORD, k_x, pick_gap(1'b0));
    // Key differs in length only: must not match.
    k_near        = k_x;
    k_near.length = 64'h1001;
    k_near.access = 2'd0;
    send_word(parl_pkg::ACT_RECORD, k_near, pick_gap(1'b0));
    k_x.access = 2'd0;
    send_word(parl_pkg::ACT_RECORD, k_x, pick_gap(1'b0));
    k_y.access = 2'd0;
    send_word(parl_pkg::ACT_RECORD, k_y, pick_gap(1'b0));
    send_word(parl_pkg::ACT_DRAIN, fresh_key(), pick_gap(1'b0));
  endtask

  // Fill the log, then push past the top with refused and accepted words.
  task automatic fill_phase(input bit no_idle);
    parl_pkg::parl_entry_t req;
    int                    extra;
    while (shadow_count < DEPTH) begin
      req = ($urandom_range(0, 2) == 0) ? pool_key() : fresh_key();
      req.access = 2'($urandom_range(1, 3));
      if (shadow_count > 0 && $urandom_range(0, 6) == 0) begin
        req        = stored_key();
        req.access = '0;
      end
      send_word(parl_pkg::ACT_RECORD, req, pick_gap(no_idle));
    end
    extra = $urandom_range(3, 8);
    repeat (extra) begin
      case ($urandom_range(0, 2))
        0: begin
          req = fresh_key();
          req.access = 2'($urandom_range(1, 3));
        end
        1: begin
          // Revoke that misses: would append, so refused while full.
          req        = fresh_key();
          req.access = '0;
        end
        default: begin
          // Stored grant: a revoke that hits, even when full; else a grant.
          req        = stored_key();
          req.access = (req.access == '0) ? 2'($urandom_range(1, 3)) : 2'd0;
        end
      endcase
      send_word(parl_pkg::ACT_RECORD, req, pick_gap(no_idle));
    end
    if ($urandom_range(0, 3) != 0)
      send_word(parl_pkg::ACT_DRAIN, fresh_key(), pick_gap(no_idle));
  endtask

  // Mixed grants, revokes, drains and raw noise on recurring keys.
  task automatic churn_phase(input bit no_idle);
    parl_pkg::parl_entry_t req;
    int                    n;
    int                    r;
    n = $urandom_range(4, 30);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        req = ($urandom_range(0, 1) == 0) ? pool_key() : fresh_key();
        req.access = 2'($urandom_range(1, 3));
        send_word(parl_pkg::ACT_RECORD, req, pick_gap(no_idle));
      end else if (r < 80) begin
        req = (shadow_count > 0 && $urandom_range(0, 9) < 7) ? stored_key() : pool_key();
        req.access = '0;
        send_word(parl_pkg::ACT_RECORD, req, pick_gap(no_idle));
      end else if (r < 88) begin
        send_word(parl_pkg::ACT_DRAIN, fresh_key(), pick_gap(no_idle));
      end else begin
        send_word(1'($urandom_range(0, 1)), fresh_key(), pick_gap(no_idle));
      end
    end
    if ($urandom_range(0, 4) < 3)
      send_word(parl_pkg::ACT_DRAIN, fresh_key(), pick_gap(no_idle));
  endtask

  // Random traffic: open with a fill so the full log is always reached.
  task automatic test_random_traffic();
    int target;
    bit no_idle;
    target  = words_sent + RAND_WORDS;
    no_idle = ($urandom_range(0, 1) == 0);
    fill_phase(no_idle);
    while (words_sent < target) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 5) == 0)
        fill_phase(no_idle);
      else
        churn_phase(no_idle);
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_action       = parl_pkg::ACT_RECORD;
    in_segment      = '0;
    in_source_id    = '0;
    in_base_address = '0;
    in_length       = '0;
    in_access       = '0;
    shadow_count    = 0;
    words_sent      = 0;
    fail_count      = 0;
    for (int i = 0; i < POOL_SIZE; i++)
      key_pool[i] = fresh_key();
    // Hold reset, then release it on an edge.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_drain();
    test_field_extremes();
    test_revoke_order();
    test_random_traffic();

    // Drop start and let every owed word come out.
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
